@@ rtl/lrjs_pkg.sv @@
`timescale 1ns / 1ps
// lrjs_pkg: shared types and constants of the longest remaining job scheduler
// used by lrjs_ctrl, lrjs_dp and longest_remaining_job_scheduler
package lrjs_pkg;

	localparam int SLOTS_DEF     = 8;
	localparam int TIME_BITS_DEF = 16;
	localparam int JOB_W         = 8;
	localparam int FIELD_W       = 16;

	localparam logic REQ_ADD  = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_SCAN,
		ST_DRAIN,
		ST_UPDATE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic capture;
		logic add_commit;
		logic scan_rd;
		logic tick_update;
		logic tick_finish;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
	} status_t;

endpackage

@@ rtl/longest_remaining_job_scheduler.sv @@
`timescale 1ns / 1ps
// longest_remaining_job_scheduler: an add request runs through the ADD state, a tick request
// through SCAN, DRAIN, UPDATE and FINISH; the slot scan reads one table slot per cycle
// through a single read port. busy stays high until the result is on the ports, and the
// next start is taken in the cycle that done is high. Results cannot be stalled.
// arst_n clears all slots and the time counter; slot payload needs no clearing.
// depends on lrjs_pkg, lrjs_ctrl, lrjs_dp
module longest_remaining_job_scheduler #(
	parameter int SLOTS     = lrjs_pkg::SLOTS_DEF,
	parameter int TIME_BITS = lrjs_pkg::TIME_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         req_type,
	input  logic [lrjs_pkg::JOB_W-1:0]   job_id,
	input  logic [lrjs_pkg::FIELD_W-1:0] arrival_time,
	input  logic [lrjs_pkg::FIELD_W-1:0] burst_length,
	output logic                         done,
	output logic                         accepted,
	output logic                         ran_valid,
	output logic [lrjs_pkg::JOB_W-1:0]   ran_job,
	output logic                         finished,
	output logic [lrjs_pkg::FIELD_W-1:0] completion_time,
	output logic [lrjs_pkg::FIELD_W-1:0] turnaround_time,
	output logic [lrjs_pkg::FIELD_W-1:0] waiting_time
);

	lrjs_pkg::cmd_t    cmd;
	lrjs_pkg::status_t sts;

	lrjs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	lrjs_dp #(
		.SLOTS     (SLOTS),
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.job_id          (job_id),
		.arrival_time    (arrival_time),
		.burst_length    (burst_length),
		.done            (done),
		.accepted        (accepted),
		.ran_valid       (ran_valid),
		.ran_job         (ran_job),
		.finished        (finished),
		.completion_time (completion_time),
		.turnaround_time (turnaround_time),
		.waiting_time    (waiting_time)
	);

endmodule

@@ rtl/lrjs_ctrl.sv @@
`timescale 1ns / 1ps
// lrjs_ctrl: request sequencer of the scheduler (add, slot scan, update, report)
// depends on lrjs_pkg for state, command and status types
module lrjs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              req_type,
	input  lrjs_pkg::status_t sts,
	output lrjs_pkg::cmd_t    cmd,
	output logic              busy
);

	lrjs_pkg::state_t state_q;
	lrjs_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrjs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			lrjs_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d = (req_type == lrjs_pkg::REQ_TICK) ? lrjs_pkg::ST_SCAN
					                                           : lrjs_pkg::ST_ADD;
				end
			end
			lrjs_pkg::ST_ADD: begin
				cmd.add_commit = 1'b1;
				state_d = lrjs_pkg::ST_IDLE;
			end
			lrjs_pkg::ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) begin
					state_d = lrjs_pkg::ST_DRAIN;
				end
			end
			lrjs_pkg::ST_DRAIN: begin
				state_d = lrjs_pkg::ST_UPDATE;
			end
			lrjs_pkg::ST_UPDATE: begin
				cmd.tick_update = 1'b1;
				state_d = lrjs_pkg::ST_FINISH;
			end
			lrjs_pkg::ST_FINISH: begin
				cmd.tick_finish = 1'b1;
				state_d = lrjs_pkg::ST_IDLE;
			end
			default: begin
				state_d = lrjs_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/lrjs_dp.sv @@
`timescale 1ns / 1ps
// lrjs_dp: slot table, slot scan compare, time counter and result registers
// depends on lrjs_pkg for command and status types and field widths
module lrjs_dp #(
	parameter int SLOTS     = lrjs_pkg::SLOTS_DEF,
	parameter int TIME_BITS = lrjs_pkg::TIME_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lrjs_pkg::cmd_t               cmd,
	output lrjs_pkg::status_t            sts,
	input  logic [lrjs_pkg::JOB_W-1:0]   job_id,
	input  logic [lrjs_pkg::FIELD_W-1:0] arrival_time,
	input  logic [lrjs_pkg::FIELD_W-1:0] burst_length,
	output logic                         done,
	output logic                         accepted,
	output logic                         ran_valid,
	output logic [lrjs_pkg::JOB_W-1:0]   ran_job,
	output logic                         finished,
	output logic [lrjs_pkg::FIELD_W-1:0] completion_time,
	output logic [lrjs_pkg::FIELD_W-1:0] turnaround_time,
	output logic [lrjs_pkg::FIELD_W-1:0] waiting_time
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int JW    = lrjs_pkg::JOB_W;
	localparam int FW    = lrjs_pkg::FIELD_W;

	// slot table payload
	logic [JW-1:0]        mem_job  [SLOTS];
	logic [TIME_BITS-1:0] mem_arr  [SLOTS];
	logic [TIME_BITS-1:0] mem_rem  [SLOTS];
	logic [TIME_BITS-1:0] mem_orig [SLOTS];

	logic [SLOTS-1:0]     used_q;
	logic [TIME_BITS-1:0] time_q;

	logic [JW-1:0]        job_q;
	logic [TIME_BITS-1:0] arr_q;
	logic [TIME_BITS-1:0] burst_q;

	logic [IDX_W-1:0]     cnt_q;

	logic                 rd_valid_s1;
	logic [IDX_W-1:0]     rd_idx_s1;
	logic [JW-1:0]        rd_job_s1;
	logic [TIME_BITS-1:0] rd_arr_s1;
	logic [TIME_BITS-1:0] rd_rem_s1;
	logic [TIME_BITS-1:0] rd_orig_s1;

	logic                 best_valid_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [JW-1:0]        best_job_q;
	logic [TIME_BITS-1:0] best_arr_q;
	logic [TIME_BITS-1:0] best_rem_q;
	logic [TIME_BITS-1:0] best_orig_q;

	logic [TIME_BITS-1:0] tat_q;
	logic                 done_q;

	logic                 free_found;
	logic [IDX_W-1:0]     free_idx;
	logic                 add_ok;
	logic                 cand_ready;
	logic                 cand_better;
	logic [TIME_BITS-1:0] time_next;
	logic                 best_last;

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	assign add_ok    = cmd.add_commit && free_found && (burst_q != '0);
	assign time_next = (time_q != '1) ? time_q + 1'b1 : time_q;
	assign best_last = (best_rem_q == TIME_BITS'(1));

	assign cand_ready  = used_q[rd_idx_s1] && (rd_rem_s1 != '0) && (rd_arr_s1 <= time_q);
	assign cand_better = !best_valid_q || (rd_rem_s1 > best_rem_q) ||
	                     ((rd_rem_s1 == best_rem_q) && (rd_arr_s1 < best_arr_q));

	assign sts.scan_last = (cnt_q == IDX_W'(SLOTS - 1));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			job_q   <= job_id;
			arr_q   <= TIME_BITS'(arrival_time);
			burst_q <= TIME_BITS'(burst_length);
		end
	end

	// table write and scan read
	always_ff @(posedge clk) begin
		if (add_ok) begin
			mem_job[free_idx]  <= job_q;
			mem_arr[free_idx]  <= arr_q;
			mem_rem[free_idx]  <= burst_q;
			mem_orig[free_idx] <= burst_q;
		end else if (cmd.tick_update && best_valid_q) begin
			mem_rem[best_idx_q] <= best_rem_q - 1'b1;
		end
		if (cmd.scan_rd) begin
			rd_idx_s1  <= cnt_q;
			rd_job_s1  <= mem_job[cnt_q];
			rd_arr_s1  <= mem_arr[cnt_q];
			rd_rem_s1  <= mem_rem[cnt_q];
			rd_orig_s1 <= mem_orig[cnt_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			time_q       <= '0;
			cnt_q        <= '0;
			rd_valid_s1  <= 1'b0;
			best_valid_q <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.scan_rd;
			done_q      <= cmd.add_commit || cmd.tick_finish;
			if (cmd.capture) begin
				cnt_q        <= '0;
				best_valid_q <= 1'b0;
			end else if (cmd.scan_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (rd_valid_s1 && cand_ready && cand_better) begin
				best_valid_q <= 1'b1;
			end
			if (add_ok) begin
				used_q[free_idx] <= 1'b1;
			end else if (cmd.tick_update && best_valid_q && best_last) begin
				used_q[best_idx_q] <= 1'b0;
			end
			if (cmd.tick_update) begin
				time_q <= time_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_valid_s1 && cand_ready && cand_better) begin
			best_idx_q  <= rd_idx_s1;
			best_job_q  <= rd_job_s1;
			best_arr_q  <= rd_arr_s1;
			best_rem_q  <= rd_rem_s1;
			best_orig_q <= rd_orig_s1;
		end
		if (cmd.tick_update) begin
			tat_q <= time_next - best_arr_q;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.add_commit) begin
			accepted        <= add_ok;
			ran_valid       <= 1'b0;
			ran_job         <= '0;
			finished        <= 1'b0;
			completion_time <= '0;
			turnaround_time <= '0;
			waiting_time    <= '0;
		end else if (cmd.tick_finish) begin
			accepted        <= 1'b1;
			ran_valid       <= best_valid_q;
			ran_job         <= best_valid_q ? best_job_q : '0;
			finished        <= best_valid_q && best_last;
			completion_time <= '0;
			turnaround_time <= '0;
			waiting_time    <= '0;
			if (best_valid_q && best_last) begin
				completion_time <= FW'(time_q);
				turnaround_time <= FW'(tat_q);
				waiting_time    <= (tat_q >= best_orig_q) ? FW'(tat_q - best_orig_q) : '0;
			end
		end
	end

	assign done = done_q;

endmodule

@@ bench/lrjs_checker.sv @@
`timescale 1ns / 1ps
// lrjs_checker: predicts the result of every accepted scheduler transfer and compares each
// strobed result field by field; depends on lrjs_pkg
module lrjs_checker
	import lrjs_pkg::*;
#(
	parameter int SLOTS     = SLOTS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               req_type,
	input  logic [JOB_W-1:0]   job_id,
	input  logic [FIELD_W-1:0] arrival_time,
	input  logic [FIELD_W-1:0] burst_length,
	input  logic               done,
	input  logic               accepted,
	input  logic               ran_valid,
	input  logic [JOB_W-1:0]   ran_job,
	input  logic               finished,
	input  logic [FIELD_W-1:0] completion_time,
	input  logic [FIELD_W-1:0] turnaround_time,
	input  logic [FIELD_W-1:0] waiting_time,
	output int                 pending,
	output int                 fail_count
);

	typedef struct packed {
		logic               accepted;
		logic               ran_valid;
		logic [JOB_W-1:0]   ran_job;
		logic               finished;
		logic [FIELD_W-1:0] completion_time;
		logic [FIELD_W-1:0] turnaround_time;
		logic [FIELD_W-1:0] waiting_time;
	} sched_result_t;

	logic                 slot_live  [SLOTS];
	logic [JOB_W-1:0]     slot_id    [SLOTS];
	logic [TIME_BITS-1:0] slot_arr   [SLOTS];
	logic [TIME_BITS-1:0] slot_left  [SLOTS];
	logic [TIME_BITS-1:0] slot_burst [SLOTS];
	logic [TIME_BITS-1:0] clock_now;
	sched_result_t        result_q[$];
	int                   mismatches = 0;

	function automatic sched_result_t schedule_step(input logic rt, input logic [JOB_W-1:0] id,
			input logic [FIELD_W-1:0] arr, input logic [FIELD_W-1:0] bl);
		sched_result_t        res;
		logic [TIME_BITS-1:0] burst;
		logic [TIME_BITS-1:0] tat;
		logic [TIME_BITS-1:0] wait_t;
		int                   free_slot;
		int                   pick;
		res = '0;
		free_slot = -1;
		pick = -1;
		burst = TIME_BITS'(bl);
		if (rt == REQ_ADD) begin
			for (int i = 0; i < SLOTS; i++)
				if (!slot_live[i] && free_slot < 0)
					free_slot = i;
			if (free_slot >= 0 && burst != '0) begin
				slot_live[free_slot] = 1'b1;
				slot_id[free_slot] = id;
				slot_arr[free_slot] = TIME_BITS'(arr);
				slot_left[free_slot] = burst;
				slot_burst[free_slot] = burst;
				res.accepted = 1'b1;
			end
			return res;
		end
		// longest remaining first, ties to earlier arrival, then lower slot
		for (int i = 0; i < SLOTS; i++) begin
			if (!slot_live[i] || slot_left[i] == '0 || slot_arr[i] > clock_now)
				continue;
			if (pick < 0 || slot_left[i] > slot_left[pick] ||
					(slot_left[i] == slot_left[pick] && slot_arr[i] < slot_arr[pick]))
				pick = i;
		end
		if (clock_now != '1)
			clock_now = clock_now + 1'b1;
		res.accepted = 1'b1;
		if (pick < 0)
			return res;
		res.ran_valid = 1'b1;
		res.ran_job = slot_id[pick];
		slot_left[pick] = slot_left[pick] - 1'b1;
		if (slot_left[pick] == '0) begin
			tat = clock_now - slot_arr[pick];
			wait_t = (tat >= slot_burst[pick]) ? tat - slot_burst[pick] : '0;
			res.finished = 1'b1;
			res.completion_time = FIELD_W'(clock_now);
			res.turnaround_time = FIELD_W'(tat);
			res.waiting_time = FIELD_W'(wait_t);
			slot_live[pick] = 1'b0;
		end
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: scheduler mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		sched_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				slot_live[i] = 1'b0;
			clock_now = '0;
			result_q.delete();
			pending <= 0;
		end else begin
			if (done) begin
				if (result_q.size() == 0) begin
					report_mismatch("result strobe with no transfer outstanding");
				end else begin
					want = result_q.pop_front();
					check_field("accepted", accepted, want.accepted);
					check_field("ran_valid", ran_valid, want.ran_valid);
					check_field("ran_job", ran_job, want.ran_job);
					check_field("finished", finished, want.finished);
					check_field("completion_time", completion_time, want.completion_time);
					check_field("turnaround_time", turnaround_time, want.turnaround_time);
					check_field("waiting_time", waiting_time, want.waiting_time);
				end
			end
			if (start && !busy)
				result_q.push_back(schedule_step(req_type, job_id, arrival_time, burst_length));
			pending <= result_q.size();
		end
		fail_count <= mismatches;
	end

endmodule

@@ bench/longest_remaining_job_scheduler_tb.sv @@
`timescale 1ns / 1ps
// longest_remaining_job_scheduler_tb: drives directed, random and far-arrival request
// streams into the scheduler and reports the verdict; depends on lrjs_pkg, lrjs_checker
module longest_remaining_job_scheduler_tb;
	import lrjs_pkg::*;

	localparam int TIME_MAX = (1 << FIELD_W) - 1;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               req_type = REQ_ADD;
	logic [JOB_W-1:0]   job_id = '0;
	logic [FIELD_W-1:0] arrival_time = '0;
	logic [FIELD_W-1:0] burst_length = '0;
	logic               done;
	logic               accepted;
	logic               ran_valid;
	logic [JOB_W-1:0]   ran_job;
	logic               finished;
	logic [FIELD_W-1:0] completion_time;
	logic [FIELD_W-1:0] turnaround_time;
	logic [FIELD_W-1:0] waiting_time;
	int                 pending;
	int                 fail_count;
	int                 sched_clock = 0;

	always #5 clk = ~clk;

	longest_remaining_job_scheduler i_dut (.*);

	lrjs_checker i_checker (.*);

	task automatic issue_request(input logic rt, input logic [JOB_W-1:0] id,
			input logic [FIELD_W-1:0] arr, input logic [FIELD_W-1:0] bl, input bit gaps);
		while (gaps && $urandom_range(0, 99) < 15) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req_type <= rt;
		job_id <= id;
		arrival_time <= arr;
		burst_length <= bl;
		do
			@(posedge clk);
		while (busy);
		if (rt == REQ_TICK && sched_clock < TIME_MAX)
			sched_clock++;
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int pick;
		int arr;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle tick, zero burst, ties on remaining and arrival, full table
		issue_request(REQ_TICK, '0, '0, '0, 1'b1);
		issue_request(REQ_ADD, 8'h00, 16'd0, 16'd0, 1'b1);
		issue_request(REQ_ADD, 8'hA5, 16'd2, 16'd3, 1'b1);
		issue_request(REQ_ADD, 8'h5A, 16'd1, 16'd3, 1'b1);
		issue_request(REQ_ADD, 8'h3C, 16'd1, 16'd3, 1'b1);
		issue_request(REQ_ADD, 8'h11, 16'd0, 16'd1, 1'b1);
		issue_request(REQ_ADD, 8'h22, 16'd0, 16'd2, 1'b1);
		issue_request(REQ_ADD, 8'h33, 16'd40, 16'd2, 1'b1);
		issue_request(REQ_ADD, 8'h44, 16'd3, 16'd1, 1'b1);
		issue_request(REQ_ADD, 8'hFF, 16'd0, 16'd4, 1'b1);
		issue_request(REQ_ADD, 8'h80, 16'hFFFF, 16'hFFFF, 1'b1);
		repeat (13)
			issue_request(REQ_TICK, '0, '0, '0, 1'b1);
		drain_results();

		repeat (310) begin
			pick = $urandom_range(0, 99);
			if (pick < 68) begin
				issue_request(REQ_TICK, '0, '0, '0, 1'b1);
			end else if (pick < 92) begin
				arr = sched_clock + int'($urandom_range(0, 8)) - 4;
				if (arr < 0)
					arr = 0;
				if (arr > TIME_MAX)
					arr = TIME_MAX;
				issue_request(REQ_ADD, JOB_W'($urandom), FIELD_W'(arr),
					($urandom_range(0, 19) == 0) ? FIELD_W'($urandom_range(13, 40)) :
					FIELD_W'($urandom_range(1, 5)), 1'b1);
			end else if (pick < 97) begin
				issue_request(REQ_ADD, JOB_W'($urandom), FIELD_W'($urandom), '0, 1'b1);
			end else begin
				issue_request(REQ_TICK, JOB_W'($urandom), FIELD_W'($urandom),
					FIELD_W'($urandom), 1'b1);
			end
		end

		// far future arrivals, then a back to back stretch of ticks
		issue_request(REQ_ADD, 8'hC1, 16'd65530, 16'd20, 1'b1);
		issue_request(REQ_ADD, 8'hC2, 16'd65530, 16'd20, 1'b1);
		issue_request(REQ_ADD, 8'hC3, 16'hFFFF, 16'd2, 1'b1);
		repeat (60)
			issue_request(REQ_TICK, '0, '0, '0, 1'b0);
		issue_request(REQ_ADD, 8'h7E, 16'd0, 16'hFFFF, 1'b1);
		repeat (4)
			issue_request(REQ_TICK, '0, '0, '0, 1'b1);

		drain_results();
		repeat (SLOTS_DEF + 8) @(posedge clk);
		if (fail_count == 0)
			$display("** longest_remaining_job_scheduler: PASSED **");
		else
			$display("** longest_remaining_job_scheduler: FAILED **");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("** longest_remaining_job_scheduler: FAILED **");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/lrjs_pkg.sv
rtl/lrjs_ctrl.sv
rtl/lrjs_dp.sv
rtl/longest_remaining_job_scheduler.sv
bench/lrjs_checker.sv
bench/longest_remaining_job_scheduler_tb.sv
